// ===== rtl/ldse_pkg.sv =====
// shared types, constants and tables for the kernel block
`default_nettype none
package ldse_pkg;
   localparam int LinW  = 24;
   localparam int DistW = 40;
   localparam int QueueDepth = 4;
   localparam int QueueAw = 2;
   localparam logic signed [LinW-1:0] LinMax = 24'sh7FFFFF;
   localparam logic signed [LinW-1:0] LinMin = -24'sh800000;
   localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
   localparam logic [16:0] Log2eQ16 = 17'd94548;

   localparam logic [1:0] RegLinOffset = 2'd0;
   localparam logic [1:0] RegLinScale  = 2'd1;
   localparam logic [1:0] RegSeScale   = 2'd2;

   // one finished row pair handed from front to back
   typedef struct packed {
      logic signed [LinW-1:0] lin_sum;
      logic [DistW-1:0]       dist_sum;
   } pair_type;

   function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/ldse_front.sv =====
// front end: accumulates row sums and pushes finished pairs
`default_nettype none
module ldse_front import ldse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] lin_offset,
   input  wire logic               in_take,
   input  wire logic signed [15:0] x_elem,
   input  wire logic signed [15:0] y_elem,
   input  wire logic               lin_valid,
   input  wire logic signed [15:0] p_elem,
   input  wire logic signed [15:0] q_elem,
   input  wire logic               se_valid,
   input  wire logic               last_elem,
   output logic                    push,
   output pair_type                push_data
);
   logic signed [LinW-1:0] lin_ff, lin_in;
   logic [DistW-1:0]       dist_ff, dist_in;
   logic signed [LinW+1:0] lin_wide;
   logic signed [16:0]     diff;
   logic [16:0]            adiff;
   logic [DistW:0]         dist_wide;

   // saturating accumulation of both sums
   always_comb begin
      lin_wide = {{2{lin_ff[LinW-1]}}, lin_ff} + 26'(x_elem) + 26'(y_elem)
               - 26'(lin_offset) - 26'(lin_offset);
      diff  = 17'(p_elem) - 17'(q_elem);
      adiff = diff[16] ? 17'(-diff) : 17'(diff);
      dist_wide = {1'b0, dist_ff} + 41'(adiff * adiff);
      lin_in = lin_ff;
      if (lin_valid) begin
         if (lin_wide > 26'(LinMax)) lin_in = LinMax;
         else if (lin_wide < 26'(LinMin)) lin_in = LinMin;
         else lin_in = lin_wide[LinW-1:0];
      end
      dist_in = dist_ff;
      if (se_valid) begin
         dist_in = dist_wide[DistW] ? DistMax : dist_wide[DistW-1:0];
      end
      push = in_take && last_elem;
      push_data.lin_sum  = lin_in;
      push_data.dist_sum = dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff  <= '0;
         dist_ff <= '0;
      end else if (in_take) begin
         lin_ff  <= last_elem ? '0 : lin_in;
         dist_ff <= last_elem ? '0 : dist_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/ldse_queue.sv =====
// short fifo of finished row pairs
`default_nettype none
module ldse_queue import ldse_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  pair_type  push_data,
   input  wire logic pop,
   output logic      not_empty,
   output logic      not_full,
   output pair_type  head
);
   pair_type mem [QueueDepth];
   logic [QueueAw-1:0] wp_ff, rp_ff;
   logic [QueueAw:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign not_full  = cnt_ff != (QueueAw+1)'(QueueDepth);
   assign head = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && !not_full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("fill count lost a push");
endmodule
`default_nettype wire

// ===== rtl/ldse_back.sv =====
// back end: exp approximation, product and saturation per row pair
`default_nettype none
module ldse_back import ldse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] lin_scale,
   input  wire logic [15:0]        se_scale,
   input  wire logic               have,
   input  pair_type                pair,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_kernel_value,
   output logic                    rsp_saturated
);
   typedef enum logic [2:0] {S_IDLE, S_EXPA, S_EXPB, S_EXPC, S_MULA, S_MULB, S_OUT}
      state_type;
   state_type state_ff;
   logic [55:0] e_ff;
   logic [40:0] u_ff;
   logic [16:0] ev_ff;
   logic [23:0] mag_ff;
   logic        neg_ff;
   logic [31:0] s2_ff;
   logic [53:0] ms_ff;
   logic [56:0] prod_ff;
   logic signed [31:0] val_ff;
   logic        sat_ff;

   logic [47:0] t_w;
   logic [15:0] f_w;
   logic [16:0] lo_w, hi_w, v_w;
   logic [28:0] corr_w;
   logic [24:0] kv_w;
   logic [23:0] k_w;

   // exp interpolation from the scaled exponent
   always_comb begin
      t_w  = e_ff[55:8];
      k_w  = u_ff[39:16];
      f_w  = u_ff[15:0];
      lo_w = exp2_tab({1'b0, f_w[15:12]});
      hi_w = exp2_tab(5'({1'b0, f_w[15:12]}) + 5'd1);
      corr_w = 29'(lo_w - hi_w) * 29'(f_w[11:0]);
      v_w  = lo_w - 17'(corr_w >> 12);
      kv_w = {8'd0, v_w} >> k_w[4:0];
      pop = (state_ff == S_IDLE) && have;
   end

   assign rsp_valid = state_ff == S_OUT;
   assign rsp_kernel_value = val_ff;
   assign rsp_saturated = sat_ff;

   // sequencer with registered operands and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (have) begin
                  e_ff   <= 56'(pair.dist_sum) * 56'(se_scale);
                  neg_ff <= pair.lin_sum[LinW-1];
                  mag_ff <= pair.lin_sum[LinW-1] ? 24'(-pair.lin_sum) : 24'(pair.lin_sum);
                  s2_ff  <= 32'(32'(signed'(lin_scale)) * 32'(signed'(lin_scale)));
                  state_ff <= S_EXPA;
               end
            end
            S_EXPA: begin
               u_ff <= 41'((65'(t_w[23:0]) * 65'(Log2eQ16)) >> 16);
               ms_ff <= 54'(mag_ff) * 54'(s2_ff);
               state_ff <= S_EXPB;
            end
            S_EXPB: begin
               if (t_w[47:24] != '0 || k_w >= 24'd17) ev_ff <= '0;
               else ev_ff <= kv_w[16:0];
               state_ff <= S_MULA;
            end
            S_MULA: begin
               prod_ff <= 57'((64'(ms_ff[53:8]) * 64'(ev_ff)) >> 16);
               state_ff <= S_MULB;
            end
            S_MULB: begin
               if (neg_ff) begin
                  sat_ff <= prod_ff > 57'h7FFFFFFF;
                  val_ff <= prod_ff > 57'h7FFFFFFF ? 32'sh7FFFFFFF : signed'(prod_ff[31:0]);
               end else begin
                  sat_ff <= prod_ff > 57'h80000000;
                  val_ff <= prod_ff > 57'h80000000 ? 32'sh80000000 : 32'(-prod_ff[31:0]);
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_kernel_value))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_EXPA)
      else $error("pop without starting work");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated && !neg_ff) |-> rsp_kernel_value == 32'sh80000000)
      else $error("bad negative clip");
endmodule
`default_nettype wire

// ===== rtl/lin_deriv_times_se_kernel.sv =====
// top level: csr port, front accumulator, pair queue and back end
// pair path: queue, then back states idle, expa, expb, mula, mulb, out
// one input beat per cycle unless stalled; back end pops a pair only when idle
// the 4-entry queue absorbs short row pairs; req_stall rises when it fills
// reset: synchronous active-high; clears sums, queue, sequencer and csrs
// csr reset values: lin_offset 0, lin_scale 1.0, se_scale 0.5
`default_nettype none
module lin_deriv_times_se_kernel import ldse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_x_elem,
   input  wire logic signed [15:0] req_y_elem,
   input  wire logic               req_lin_valid,
   input  wire logic signed [15:0] req_p_elem,
   input  wire logic signed [15:0] req_q_elem,
   input  wire logic               req_se_valid,
   input  wire logic               req_last_elem,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_kernel_value,
   output logic                    rsp_saturated,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   logic signed [15:0] off_ff, scl_ff;
   logic [15:0] se_ff;
   logic in_take, push, pop, not_empty, not_full;
   pair_type push_data, head;

   assign pready = 1'b1;
   assign req_stall = !not_full;
   assign in_take = req_valid && !req_stall;

   // csr write and read
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= 16'sd0;
         scl_ff <= 16'sd256;
         se_ff  <= 16'd128;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            RegLinOffset: off_ff <= pwdata[15:0];
            RegLinScale:  scl_ff <= pwdata[15:0];
            RegSeScale:   se_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         RegLinOffset: prdata = {{16{off_ff[15]}}, off_ff};
         RegLinScale:  prdata = {{16{scl_ff[15]}}, scl_ff};
         RegSeScale:   prdata = {16'd0, se_ff};
         default:      prdata = '0;
      endcase
   end

   ldse_front u_front (
      .clock, .reset, .lin_offset(off_ff), .in_take,
      .x_elem(req_x_elem), .y_elem(req_y_elem), .lin_valid(req_lin_valid),
      .p_elem(req_p_elem), .q_elem(req_q_elem), .se_valid(req_se_valid),
      .last_elem(req_last_elem), .push, .push_data
   );

   ldse_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .not_empty, .not_full, .head
   );

   ldse_back u_back (
      .clock, .reset, .lin_scale(scl_ff), .se_scale(se_ff), .have(not_empty),
      .pair(head), .pop, .rsp_valid, .rsp_stall, .rsp_kernel_value, .rsp_saturated
   );
endmodule
`default_nettype wire

// ===== test/tb_lin_deriv_times_se_kernel.sv =====
// testbench for the linear-derivative times squared-exponential kernel block
`timescale 1ns / 100ps
`default_nettype none
module tb_lin_deriv_times_se_kernel;
   import ldse_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_x_elem = '0, req_y_elem = '0, req_p_elem = '0, req_q_elem = '0;
   logic req_lin_valid = 1'b0, req_se_valid = 1'b0, req_last_elem = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_kernel_value;
   logic rsp_saturated;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   lin_deriv_times_se_kernel dut (
      .clock, .reset, .req_valid, .req_stall, .req_x_elem, .req_y_elem, .req_lin_valid,
      .req_p_elem, .req_q_elem, .req_se_valid, .req_last_elem, .rsp_valid, .rsp_stall,
      .rsp_kernel_value, .rsp_saturated, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready
   );

   always #6 clock = ~clock;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sat;
   } kernel_result_type;

   // predictor copy of registers and sums
   logic signed [15:0] offset_r = 16'sd0, scale_r = 16'sd256;
   logic [15:0] se_scale_r = 16'd128;
   logic signed [23:0] lin_sum = '0;
   logic [39:0] dist_sum = '0;
   kernel_result_type pending_results[$];

   int send_idle_pct = 0, recv_idle_pct = 0;
   bit hold_off = 1'b0;
   int n_items = 0, n_results = 0, n_sat = 0, n_errors = 0;

   localparam logic [16:0] Pow2Tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773,
      50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   function automatic logic [63:0] decay_q16(input logic [63:0] t);
      logic [63:0] u, k, f, lo, hi;
      if (t >= 64'd16777216) return 0;
      u = (t * 64'd94548) >> 16;
      k = u >> 16;
      if (k >= 17) return 0;
      f = u & 64'hFFFF;
      lo = Pow2Tab[f >> 12];
      hi = Pow2Tab[(f >> 12) + 1];
      return (lo - (((lo - hi) * (f & 64'hFFF)) >> 12)) >> k;
   endfunction

   // fold one accepted beat into the sums, emit expectation on last
   task automatic predict_beat(input logic signed [15:0] x, y, p, q,
                               input logic lv, sv, last);
      longint acc, d, s2, mag;
      logic [63:0] prod, ev;
      logic [40:0] dacc;
      kernel_result_type r;
      if (lv) begin
         acc = longint'(lin_sum) + x + y - 2 * longint'(offset_r);
         if (acc > 8388607) acc = 8388607;
         if (acc < -8388608) acc = -8388608;
         lin_sum = acc[23:0];
      end
      if (sv) begin
         d = longint'(p) - longint'(q);
         dacc = dist_sum + 41'(d * d);
         dist_sum = dacc[40] ? 40'hFF_FFFF_FFFF : dacc[39:0];
      end
      if (!last) return;
      s2 = longint'(scale_r) * longint'(scale_r);
      ev = decay_q16((64'(dist_sum) * 64'(se_scale_r)) >> 8);
      mag = lin_sum < 0 ? -longint'(lin_sum) : longint'(lin_sum);
      prod = (((64'(mag) * 64'(s2)) >> 8) * ev) >> 16;
      r.sat = 1'b0;
      if (lin_sum < 0) begin
         if (prod > 64'd2147483647) begin prod = 64'd2147483647; r.sat = 1'b1; end
         r.value = prod[31:0];
      end else begin
         if (prod > 64'd2147483648) begin prod = 64'd2147483648; r.sat = 1'b1; end
         r.value = -$signed(prod[31:0]);
      end
      pending_results.push_back(r);
      lin_sum = '0;
      dist_sum = '0;
   endtask

   // send one beat, honoring stall and random sender gaps
   // valid stays high after acceptance; a sender gap or a drain drops it
   task automatic send_beat(input logic signed [15:0] x, y, p, q,
                            input logic lv, sv, last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_elem <= x; req_y_elem <= y; req_p_elem <= p; req_q_elem <= q;
      req_lin_valid <= lv; req_se_valid <= sv; req_last_elem <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(x, y, p, q, lv, sv, last);
      n_items++;
   endtask

   task automatic rand_beat(input logic last);
      send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(9) != 0, $urandom_range(9) != 0, last);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         RegLinOffset: offset_r = val;
         RegLinScale:  scale_r = val;
         default:      se_scale_r = val;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] off, scl, se);
      wait_drained();
      csr_write(RegLinOffset, off);
      csr_write(RegLinScale, scl);
      csr_write(RegSeScale, se);
   endtask

   // random row pairs of mostly short length, a few long ones
   task automatic run_random_pairs(input int n_beats);
      int len, sent;
      sent = 0;
      while (sent < n_beats) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(64, 90) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) rand_beat(i == len - 1);
         sent += len;
      end
   endtask

   // directed corner cases
   task automatic test_directed();
      send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 1'b1, 1'b1, 1'b1);
      send_beat(-16'sh8000, -16'sh8000, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 1'b1);
      send_beat(16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b1);
      send_beat(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b1);
      send_beat(16'sh0080, -16'sh0200, 16'sh0010, 16'sh0000, 1'b1, 1'b1, 1'b0);
      send_beat(16'sh1234, 16'sh4321, 16'sh0020, 16'sh0010, 1'b0, 1'b1, 1'b1);
      send_beat(-16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b1);
      // long row that saturates both sums
      for (int i = 0; i < 300; i++)
         send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 1'b1, 1'b1, i == 299);
   endtask

   task automatic test_configs();
      set_config(16'h8000, 16'h7FFF, 16'h0000);
      for (int i = 0; i < 6; i++) rand_beat(1'(i % 2));
      set_config(16'h7FFF, 16'h8000, 16'hFFFF);
      for (int i = 0; i < 6; i++) rand_beat(1'(i % 2));
      set_config(16'h0000, 16'h0100, 16'h0001);
      send_beat(16'sh0100, 16'sh0100, 16'sh0010, 16'sh0000, 1'b1, 1'b1, 1'b1);
      send_beat(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0000, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_random_phases();
      send_idle_pct = 26; recv_idle_pct = 52;
      set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)));
      run_random_pairs(250);
      send_idle_pct = 52; recv_idle_pct = 26;
      set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)));
      run_random_pairs(250);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_config(16'($urandom), 16'h0100, 16'h0080);
      run_random_pairs(250);
   endtask

   // receiver holds off long while short pairs keep coming
   task automatic test_backpressure();
      wait_drained();
      fork
         begin
            @(negedge clock);
            hold_off = 1'b1;
            for (int c = 0; c < 200; c++) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 20; i++) rand_beat(1'b1);
      join
   endtask

   // receiver stall driving
   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

   // result checker
   always @(posedge clock) begin
      kernel_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rsp_saturated) n_sat++;
         if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result %0d", rsp_kernel_value);
         end else begin
            exp_r = pending_results.pop_front();
            if (exp_r.value !== rsp_kernel_value || exp_r.sat !== rsp_saturated) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch: expected %0d sat %0b, got %0d sat %0b",
                           exp_r.value, exp_r.sat, rsp_kernel_value, rsp_saturated);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_configs();
      test_random_phases();
      test_backpressure();
      wait_drained();
      n_errors += pending_results.size();
      $display("sent %0d beats, checked %0d kernel entries (%0d saturated)",
               n_items, n_results, n_sat);
      if (n_errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/ldse_pkg.sv
rtl/ldse_front.sv
rtl/ldse_queue.sv
rtl/ldse_back.sv
rtl/lin_deriv_times_se_kernel.sv
test/tb_lin_deriv_times_se_kernel.sv
